[design/afb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afb_pkg
// Shared types, constants and the CRC_A byte step for the frame builder.
// ----------------------------------------------------------------------------
package afb_pkg;

    localparam int unsigned MEM_BYTES_DEF = 8192;

    localparam logic [15:0] CRC_INIT   = 16'h6363;
    localparam logic [7:0]  BLOCK_BYTE = 8'h02;
    localparam logic [7:0]  CLA_BYTE   = 8'h00;
    localparam logic [7:0]  INS_SELECT = 8'hA4;
    localparam logic [7:0]  INS_READ   = 8'hB0;
    localparam logic [7:0]  INS_UPDATE = 8'hD6;
    localparam logic [7:0]  SEL_P1     = 8'h00;
    localparam logic [7:0]  SEL_P2     = 8'h0C;
    localparam logic [7:0]  SEL_LC     = 8'h02;

    localparam int unsigned IDX_W = 4;

    typedef enum logic [1:0] {
        REQ_SELECT   = 2'd0,
        REQ_READ     = 2'd1,
        REQ_UPD_HDR  = 2'd2,
        REQ_UPD_DATA = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_PARAM = 2'd1,
        ST_SEQ   = 2'd2
    } status_t;

    typedef struct packed {
        req_t        req;
        logic [15:0] file_id;
        logic [15:0] offset;
        logic [7:0]  byte_count;
        logic [7:0]  data_byte;
        logic        param_err;
    } item_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_end;
        status_t    status;
    } beat_t;

    // reflected 0x1021 step, one byte
    function automatic logic [15:0] crc_a_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] t;
        t = b ^ crc[7:0];
        t = t ^ {t[3:0], 4'b0000};
        return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000}
               ^ {12'h000, t[7:4]};
    endfunction

endpackage

[design/afb_in_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afb_in_stage
// Input register; runs the count and range check as the item is captured.
// ----------------------------------------------------------------------------
module afb_in_stage #(
    parameter int unsigned MEM_BYTES = afb_pkg::MEM_BYTES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [47:0]          s_tdata,
    input  logic [1:0]           s_tuser,
    input  logic                 take,
    output logic                 item_vld,
    output afb_pkg::item_t       item
);
    import afb_pkg::*;

    localparam logic [16:0] MemLimit = 17'(MEM_BYTES);

    logic        vld_reg;
    item_t       item_reg;
    item_t       item_next;
    logic [16:0] range_end;

    assign s_tready = !vld_reg || take;

    always_comb begin
        item_next.req        = req_t'(s_tuser);
        item_next.file_id    = s_tdata[15:0];
        item_next.offset     = s_tdata[31:16];
        item_next.byte_count = s_tdata[39:32];
        item_next.data_byte  = s_tdata[47:40];
        range_end            = {1'b0, s_tdata[31:16]} + {9'd0, s_tdata[39:32]};
        item_next.param_err  = (s_tdata[39:32] == 8'd0) || (range_end > MemLimit);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (s_tready) begin
            vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg <= item_next;
        end
    end

    assign item_vld = vld_reg;
    assign item     = item_reg;

endmodule

[design/afb_frame_gen.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afb_frame_gen
// Picks the next frame byte of the held item, folds it into the CRC and
// keeps the update session state.
// ----------------------------------------------------------------------------
module afb_frame_gen (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           item_vld,
    input  afb_pkg::item_t item,
    input  logic           out_free,
    output logic           take,
    output logic           beat_vld,
    output afb_pkg::beat_t beat
);
    import afb_pkg::*;

    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       pending_reg, pending_next;
    logic             open_reg, open_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    logic             emit;
    logic             seq_err;
    logic             err;
    logic [IDX_W-1:0] last_idx;
    logic             is_last;
    logic             crc_lo, crc_hi;
    logic [7:0]       fbyte;
    logic [15:0]      crc_base;

    always_comb begin
        emit    = item_vld && out_free;
        seq_err = (item.req == REQ_UPD_DATA) ? !open_reg : open_reg;
        err     = seq_err
                  || ((item.req == REQ_READ || item.req == REQ_UPD_HDR) && item.param_err);

        fbyte  = 8'h00;
        crc_lo = 1'b0;
        crc_hi = 1'b0;
        unique case (item.req)
            REQ_SELECT: begin
                last_idx = IDX_W'(9);
                case (idx_reg)
                    IDX_W'(0): fbyte = BLOCK_BYTE;
                    IDX_W'(1): fbyte = CLA_BYTE;
                    IDX_W'(2): fbyte = INS_SELECT;
                    IDX_W'(3): fbyte = SEL_P1;
                    IDX_W'(4): fbyte = SEL_P2;
                    IDX_W'(5): fbyte = SEL_LC;
                    IDX_W'(6): fbyte = item.file_id[15:8];
                    IDX_W'(7): fbyte = item.file_id[7:0];
                    IDX_W'(8): crc_lo = 1'b1;
                    default:   crc_hi = 1'b1;
                endcase
            end
            REQ_READ, REQ_UPD_HDR: begin
                last_idx = (item.req == REQ_READ) ? IDX_W'(7) : IDX_W'(5);
                case (idx_reg)
                    IDX_W'(0): fbyte = BLOCK_BYTE;
                    IDX_W'(1): fbyte = CLA_BYTE;
                    IDX_W'(2): fbyte = (item.req == REQ_READ) ? INS_READ : INS_UPDATE;
                    IDX_W'(3): fbyte = item.offset[15:8];
                    IDX_W'(4): fbyte = item.offset[7:0];
                    IDX_W'(5): fbyte = item.byte_count;
                    IDX_W'(6): crc_lo = 1'b1;
                    default:   crc_hi = 1'b1;
                endcase
            end
            default: begin
                // last data byte of an update also carries the two crc bytes
                last_idx = (pending_reg == 8'd1) ? IDX_W'(2) : IDX_W'(0);
                case (idx_reg)
                    IDX_W'(0): fbyte = item.data_byte;
                    IDX_W'(1): crc_lo = 1'b1;
                    default:   crc_hi = 1'b1;
                endcase
            end
        endcase

        if (crc_lo) begin
            fbyte = crc_reg[7:0];
        end else if (crc_hi) begin
            fbyte = crc_reg[15:8];
        end

        if (err) begin
            is_last = 1'b1;
        end else begin
            is_last = (idx_reg == last_idx);
        end

        crc_base = (idx_reg == '0 && item.req != REQ_UPD_DATA) ? CRC_INIT : crc_reg;

        crc_next     = crc_reg;
        pending_next = pending_reg;
        open_next    = open_reg;
        idx_next     = idx_reg;
        if (emit && !err) begin
            if (crc_hi) begin
                crc_next = CRC_INIT;
            end else if (!crc_lo) begin
                crc_next = crc_a_byte(crc_base, fbyte);
            end
            idx_next = is_last ? '0 : idx_reg + IDX_W'(1);
            if (is_last && item.req == REQ_UPD_HDR) begin
                pending_next = item.byte_count;
                open_next    = 1'b1;
            end
            if (is_last && item.req == REQ_UPD_DATA) begin
                pending_next = pending_reg - 8'd1;
                if (pending_reg == 8'd1) begin
                    open_next = 1'b0;
                end
            end
        end

        take            = emit && is_last;
        beat_vld        = emit;
        beat.frame_byte = err ? 8'h00 : fbyte;
        beat.frame_end  = is_last;
        beat.status     = !err ? ST_OK : (seq_err ? ST_SEQ : ST_PARAM);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg     <= CRC_INIT;
            pending_reg <= 8'd0;
            open_reg    <= 1'b0;
            idx_reg     <= '0;
        end else begin
            crc_reg     <= crc_next;
            pending_reg <= pending_next;
            open_reg    <= open_next;
            idx_reg     <= idx_next;
        end
    end

endmodule

[design/afb_out_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afb_out_stage
// Result register; holds a beat until the downstream side takes it.
// ----------------------------------------------------------------------------
module afb_out_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           beat_vld,
    input  afb_pkg::beat_t beat,
    output logic           out_free,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata,
    output logic           m_tlast,
    output logic [1:0]     m_tuser
);
    import afb_pkg::*;

    logic  vld_reg;
    beat_t beat_reg;

    assign out_free = !vld_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (out_free) begin
            vld_reg <= beat_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && beat_vld) begin
            beat_reg <= beat;
        end
    end

    assign m_tvalid = vld_reg;
    assign m_tdata  = beat_reg.frame_byte;
    assign m_tlast  = beat_reg.frame_end;
    assign m_tuser  = beat_reg.status;

endmodule

[design/apdu_frame_builder_crc_a.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apdu_frame_builder_crc_a
// Command frame builder with CRC_A, one frame byte per output beat.
// ----------------------------------------------------------------------------
// Each input beat is a request (select file, read binary, update header or
// update data byte); the block answers with the frame bytes it causes, tlast
// on the last one, and a status in m_tuser (0 ok, 1 parameter error,
// 2 sequence error, data zero on error). The output register sends one frame
// byte per cycle unless m_tready stalls it. A request causes 1 beat for an
// error or a mid-stream data byte, 3 for the last data byte, 6 for an
// update header, 8 for read binary and 10 for select file. Update data bytes
// stream at one per cycle without stalls, and the next request is taken in
// the cycle its predecessor's last byte is loaded into the output register.
module apdu_frame_builder_crc_a #(
    parameter int unsigned MEM_BYTES = afb_pkg::MEM_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // file_id, offset, byte_count, data_byte
    input  logic [1:0]  s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // frame_byte
    output logic        m_tlast,
    output logic [1:0]  m_tuser    // status
);
    import afb_pkg::*;

    logic  take;
    logic  item_vld;
    item_t item;
    logic  out_free;
    logic  beat_vld;
    beat_t beat;

    afb_in_stage #(
        .MEM_BYTES (MEM_BYTES)
    ) u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .take     (take),
        .item_vld (item_vld),
        .item     (item)
    );

    afb_frame_gen u_gen (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .item_vld (item_vld),
        .item     (item),
        .out_free (out_free),
        .take     (take),
        .beat_vld (beat_vld),
        .beat     (beat)
    );

    afb_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .beat_vld (beat_vld),
        .beat     (beat),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

[design/afb_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afb_checker
// Port-level checks for the frame builder, bound to the top level.
// ----------------------------------------------------------------------------
module afb_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic [1:0] m_tuser
);
    import afb_pkg::*;

    // stalled beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output beat changed while stalled");

    // an error answer is a single zero byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ST_OK |-> m_tlast && m_tdata == 8'h00)
        else $error("error beat not a single zero byte");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_PARAM || m_tuser == ST_SEQ))
        else $error("undefined status code");

    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind apdu_frame_builder_crc_a afb_checker u_afb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the command frame builder with CRC_A.
// ----------------------------------------------------------------------------
// A short table of requests covers the field extremes, every request kind,
// the sequence and parameter errors and the exact memory bound. Error rows
// carry their single expected beat, while the other rows are checked against
// a frame predictor with its own CRC_A. A random phase follows, made mostly
// of complete requests and update sequences with random content, plus noise
// that breaks sequences and goes out of range. The sender works in bursts
// and the receiver stalls on its own pattern, with one long hold-off so the
// block fills up and stalls its input.
// ----------------------------------------------------------------------------
module tb;
    import afb_pkg::*;

    localparam int unsigned MEM_SIZE    = MEM_BYTES_DEF;
    localparam int unsigned N_RANDOM    = 310;
    localparam int unsigned IDLE_LIMIT  = 4000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned DRAIN_WAIT  = 16;

    typedef struct packed {
        req_t        req;
        logic [15:0] fid;
        logic [15:0] off;
        logic [7:0]  cnt;
        logic [7:0]  dat;
        logic        typed;   // expected beat given in the row
        status_t     st;
    } req_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;

    apdu_frame_builder_crc_a u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor state
    logic [15:0] crc_run;
    logic [7:0]  data_left;
    logic        upd_open;
    beat_t       frame_q[$];

    int unsigned n_fail = 0;
    int unsigned n_sent = 0;
    int unsigned burst_left = 0;

    req_row_t dir_tab [21] = '{
        '{REQ_UPD_DATA, 16'h0000, 16'h0000, 8'h00, 8'h5A, 1'b1, ST_SEQ},
        '{REQ_READ,     16'hFFFF, 16'h0000, 8'h00, 8'h00, 1'b1, ST_PARAM},
        '{REQ_UPD_HDR,  16'h0000, 16'h0000, 8'h00, 8'hFF, 1'b1, ST_PARAM},
        '{REQ_READ,     16'h0000, 16'd8000, 8'd255, 8'h00, 1'b1, ST_PARAM},
        '{REQ_READ,     16'h0000, 16'hFFFF, 8'hFF, 8'h00, 1'b1, ST_PARAM},
        '{REQ_READ,     16'h0000, 16'd7937, 8'd255, 8'h00, 1'b0, ST_OK},
        '{REQ_READ,     16'h0000, 16'h0000, 8'h01, 8'h00, 1'b0, ST_OK},
        '{REQ_READ,     16'h0000, 16'h0000, 8'hFF, 8'h00, 1'b0, ST_OK},
        '{REQ_SELECT,   16'h0000, 16'h0000, 8'h00, 8'h00, 1'b0, ST_OK},
        '{REQ_SELECT,   16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 1'b0, ST_OK},
        '{REQ_UPD_HDR,  16'h0000, 16'h1234, 8'h03, 8'h00, 1'b0, ST_OK},
        '{REQ_SELECT,   16'hABCD, 16'h0000, 8'h00, 8'h00, 1'b1, ST_SEQ},
        '{REQ_READ,     16'h0000, 16'h0000, 8'h01, 8'h00, 1'b1, ST_SEQ},
        '{REQ_UPD_HDR,  16'h0000, 16'h0000, 8'h01, 8'h00, 1'b1, ST_SEQ},
        '{REQ_UPD_DATA, 16'h0000, 16'h0000, 8'h00, 8'h00, 1'b0, ST_OK},
        '{REQ_UPD_DATA, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 1'b0, ST_OK},
        '{REQ_UPD_DATA, 16'h0000, 16'h0000, 8'h00, 8'hA5, 1'b0, ST_OK},
        '{REQ_UPD_DATA, 16'h0000, 16'h0000, 8'h00, 8'h3C, 1'b1, ST_SEQ},
        '{REQ_UPD_HDR,  16'h0000, 16'd8191, 8'h01, 8'h00, 1'b0, ST_OK},
        '{REQ_UPD_DATA, 16'h0000, 16'h0000, 8'h00, 8'hFF, 1'b0, ST_OK},
        '{REQ_UPD_HDR,  16'h0000, 16'd8192, 8'h01, 8'h00, 1'b1, ST_PARAM}
    };

    function automatic logic [15:0] crc_a_step(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            r = r[0] ? ((r >> 1) ^ 16'h8408) : (r >> 1);
        end
        return r;
    endfunction

    function automatic void push_frame_byte(input logic [7:0] b);
        crc_run = crc_a_step(crc_run, b);
        frame_q.push_back('{b, 1'b0, ST_OK});
    endfunction

    function automatic void push_crc();
        frame_q.push_back('{crc_run[7:0], 1'b0, ST_OK});
        frame_q.push_back('{crc_run[15:8], 1'b0, ST_OK});
        crc_run = CRC_INIT;
    endfunction

    // expected frame bytes for one accepted request
    function automatic void predict_frame(input req_row_t rq);
        logic err;
        status_t est;
        err = 1'b0;
        est = ST_OK;
        if (rq.req == REQ_UPD_DATA) begin
            if (!upd_open) begin
                err = 1'b1;
                est = ST_SEQ;
            end else begin
                push_frame_byte(rq.dat);
                data_left = data_left - 8'd1;
                if (data_left == 8'd0) begin
                    push_crc();
                    upd_open = 1'b0;
                end
            end
        end else if (upd_open) begin
            err = 1'b1;
            est = ST_SEQ;
        end else if (rq.req == REQ_SELECT) begin
            crc_run = CRC_INIT;
            push_frame_byte(BLOCK_BYTE);
            push_frame_byte(CLA_BYTE);
            push_frame_byte(INS_SELECT);
            push_frame_byte(SEL_P1);
            push_frame_byte(SEL_P2);
            push_frame_byte(SEL_LC);
            push_frame_byte(rq.fid[15:8]);
            push_frame_byte(rq.fid[7:0]);
            push_crc();
        end else if (rq.cnt == 8'd0 || 32'(rq.off) + 32'(rq.cnt) > MEM_SIZE) begin
            err = 1'b1;
            est = ST_PARAM;
        end else begin
            crc_run = CRC_INIT;
            push_frame_byte(BLOCK_BYTE);
            push_frame_byte(CLA_BYTE);
            push_frame_byte(rq.req == REQ_READ ? INS_READ : INS_UPDATE);
            push_frame_byte(rq.off[15:8]);
            push_frame_byte(rq.off[7:0]);
            push_frame_byte(rq.cnt);
            if (rq.req == REQ_READ) begin
                push_crc();
            end else begin
                data_left = rq.cnt;
                upd_open = 1'b1;
            end
        end
        if (err) begin
            frame_q.push_back('{8'h00, 1'b1, est});
        end else begin
            frame_q[frame_q.size() - 1].frame_end = 1'b1;
        end
    endfunction

    // offer one request beat; valid stays high into the next one within a burst
    task automatic send_request(input req_row_t rq);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {rq.dat, rq.cnt, rq.off, rq.fid};
        s_tuser  <= rq.req;
        do @(posedge aclk); while (!s_tready);
        n_sent++;
        if (rq.typed) begin
            frame_q.push_back('{8'h00, 1'b1, rq.st});
        end else begin
            predict_frame(rq);
        end
    endtask

    // receiver: random stall patterns and one long hold-off
    int unsigned rx_cyc = 0;
    int unsigned rx_mode = 0;
    int unsigned rx_mode_left = 0;
    int unsigned hold_left = 0;
    logic        hold_done = 1'b0;

    always @(posedge aclk) begin
        rx_cyc++;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (!hold_done && n_sent >= 100) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(5, 60);
            end
            rx_mode_left--;
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= (rx_cyc % 3 != 0);
            endcase
        end
    end

    // output check against the oldest expected beat
    beat_t exp_beat;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (frame_q.size() == 0) begin
                $error("unexpected beat: frame_byte %h tlast %b status %0d",
                       m_tdata, m_tlast, m_tuser);
                n_fail++;
            end else begin
                exp_beat = frame_q.pop_front();
                if (m_tdata !== exp_beat.frame_byte) begin
                    $error("frame_byte expected %h actual %h", exp_beat.frame_byte, m_tdata);
                    n_fail++;
                end
                if (m_tlast !== exp_beat.frame_end) begin
                    $error("frame_end expected %b actual %b", exp_beat.frame_end, m_tlast);
                    n_fail++;
                end
                if (m_tuser !== exp_beat.status) begin
                    $error("status expected %0d actual %0d", exp_beat.status, m_tuser);
                    n_fail++;
                end
            end
        end
    end

    // watchdog on cycles with no beat on either side
    int unsigned idle_cyc = 0;

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cyc <= 0;
            end else if (idle_cyc >= IDLE_LIMIT) begin
                $display("FAIL apdu_frame_builder_crc_a");
                $finish;
            end else begin
                idle_cyc <= idle_cyc + 1;
            end
        end
    end

    function automatic logic [7:0] pick_count();
        return ($urandom_range(0, 32) == 0) ? 8'($urandom_range(1, 255))
                                            : 8'($urandom_range(1, 6));
    endfunction

    req_row_t    rnd_rq;
    int unsigned n_rand;
    int unsigned pick;

    initial begin
        crc_run   = CRC_INIT;
        data_left = 8'd0;
        upd_open  = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_tab[i]) begin
            send_request(dir_tab[i]);
        end

        for (n_rand = 0; n_rand < N_RANDOM; n_rand++) begin
            rnd_rq.fid   = 16'($urandom);
            rnd_rq.off   = 16'($urandom);
            rnd_rq.cnt   = 8'($urandom);
            rnd_rq.dat   = 8'($urandom);
            rnd_rq.typed = 1'b0;
            rnd_rq.st    = ST_OK;
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                // noise: any kind, any field values
                rnd_rq.req = req_t'($urandom_range(0, 3));
            end else if (upd_open) begin
                rnd_rq.req = REQ_UPD_DATA;
            end else begin
                rnd_rq.req = req_t'($urandom_range(0, 2));
                rnd_rq.cnt = pick_count();
                case ($urandom_range(0, 9))
                    0: rnd_rq.off = 16'(MEM_SIZE - rnd_rq.cnt);
                    1: rnd_rq.off = 16'(MEM_SIZE + 1 - rnd_rq.cnt);
                    default: rnd_rq.off = 16'($urandom_range(0, MEM_SIZE - rnd_rq.cnt));
                endcase
            end
            send_request(rnd_rq);
        end
        s_tvalid <= 1'b0;

        while (frame_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (n_fail == 0 && frame_q.size() == 0) begin
            $display("PASS apdu_frame_builder_crc_a");
        end else begin
            $display("FAIL apdu_frame_builder_crc_a");
        end
        $finish;
    end

endmodule

[sim.f]
design/afb_pkg.sv
design/afb_in_stage.sv
design/afb_frame_gen.sv
design/afb_out_stage.sv
design/apdu_frame_builder_crc_a.sv
design/afb_checker.sv
test/tb.sv
